[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a same-cycle implication outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dfr_pkg.sv]
package dfr_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned CNT_W  = (PTR_W > CAP_W) ? PTR_W : CAP_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MSGID  = 2'd2;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_UNDO  = 1'b1;

  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] date;
    logic [31:0] hash;
    logic [31:0] serial;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [PTR_W-1:0] capacity;
    logic             check_header;
    logic             check_msgid;
  } cfg_t;

endpackage

[hdl/dfr_ram.sv]
module dfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/dfr_ctrl.sv]
`include "assert_macros.svh"

module dfr_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dfr_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  dfr_pkg::entry_t                 in_entry,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_is_dupe,
  output dfr_pkg::ram_req_t               ram_req,
  input  logic [dfr_pkg::ENTRY_W-1:0]     ram_rdata
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_RDSAVE = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_UNDO   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  localparam int unsigned PW = dfr_pkg::PTR_W;
  localparam int unsigned AW = dfr_pkg::ADDR_W;
  localparam logic [PW-1:0] PTR_MAX = PW'(dfr_pkg::DEPTH);

  state_t          state_r, state_nxt;
  dfr_pkg::entry_t item_r, item_nxt;
  dfr_pkg::entry_t saved_r, saved_nxt;
  dfr_pkg::entry_t rd_entry;
  logic            saved_vld_r, saved_vld_nxt;
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   n_r, n_nxt;
  logic [PW-1:0]   iss_r, iss_nxt;
  logic [PW-1:0]   cmp_r, cmp_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic            dupe_r, dupe_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_dupe_r, out_dupe_nxt;
  logic [PW-1:0]   cap;
  logic [PW-1:0]   wp_wrap;
  logic [PW-1:0]   wp_inc;
  logic [PW-1:0]   wp_back;
  logic            hit;
  logic            issue;

  assign rd_entry = dfr_pkg::entry_t'(ram_rdata);
  assign cap      = cfg.capacity;
  assign wp_wrap  = (wp_r >= cap) ? '0 : wp_r;
  assign wp_inc   = wp_r + PW'(1);
  assign wp_back  = ((wp_r == '0) || (wp_r > cap)) ? (cap - PW'(1)) : (wp_r - PW'(1));

  assign hit = (cfg.check_header && (item_r.crc == rd_entry.crc) &&
                (item_r.date == rd_entry.date)) ||
               (cfg.check_msgid && (item_r.hash != '0) &&
                (item_r.hash == rd_entry.hash) && (item_r.serial == rd_entry.serial));

  assign issue = (state_r == ST_SEARCH) && (iss_r < n_r) && !(rd_vld_r && hit);

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_is_dupe = out_dupe_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    saved_nxt     = saved_r;
    saved_vld_nxt = saved_vld_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    rd_vld_nxt    = issue;
    dupe_nxt      = dupe_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dupe_nxt  = out_dupe_r;
    ram_req       = '0;
    ram_req.waddr = wp_r[AW-1:0];
    ram_req.raddr = iss_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_entry;
          dupe_nxt = 1'b0;
          if (in_op == dfr_pkg::OP_CHECK) begin
            if (cap == '0) begin
              state_nxt = ST_DONE;
            end else begin
              wp_nxt    = wp_wrap;
              n_nxt     = (cnt_r < cap) ? cnt_r : cap;
              iss_nxt   = '0;
              cmp_nxt   = '0;
              state_nxt = (n_nxt == '0) ? ST_RDSAVE : ST_SEARCH;
            end
          end else begin
            state_nxt = (!saved_vld_r || (cap == '0)) ? ST_DONE : ST_UNDO;
          end
        end
      end
      ST_SEARCH: begin
        if (issue) begin
          ram_req.re = 1'b1;
          iss_nxt    = iss_r + PW'(1);
        end
        if (rd_vld_r) begin
          if (hit) begin
            dupe_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if (cmp_r == (n_r - PW'(1))) begin
            state_nxt = ST_RDSAVE;
          end else begin
            cmp_nxt = cmp_r + PW'(1);
          end
        end
      end
      ST_RDSAVE: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = wp_r[AW-1:0];
        state_nxt     = ST_WRITE;
      end
      ST_WRITE: begin
        saved_nxt     = rd_entry;
        saved_vld_nxt = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.wdata = item_r;
        wp_nxt        = wp_inc;
        if (wp_inc > cnt_r) begin
          cnt_nxt = wp_inc;
        end
        state_nxt = ST_DONE;
      end
      ST_UNDO: begin
        if ((wp_r == cnt_r) && (cnt_r != '0)) begin
          cnt_nxt = cnt_r - PW'(1);
        end
        wp_nxt        = wp_back;
        ram_req.we    = 1'b1;
        ram_req.waddr = wp_back[AW-1:0];
        ram_req.wdata = saved_r;
        saved_vld_nxt = 1'b0;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dupe_nxt  = dupe_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      saved_vld_r <= 1'b0;
      wp_r        <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      saved_vld_r <= saved_vld_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    saved_r    <= saved_nxt;
    n_r        <= n_nxt;
    iss_r      <= iss_nxt;
    cmp_r      <= cmp_nxt;
    dupe_r     <= dupe_nxt;
    out_dupe_r <= out_dupe_nxt;
  end

  `ASSERT_IMPL(a_wr_ring, clk, rst_n, ram_req.we, ({1'b0, ram_req.waddr} < cap), "write past ring")
  `ASSERT_NEXT(a_rd_follows_issue, clk, rst_n, issue, rd_vld_r, "search read lost")
  `ASSERT_IMPL(a_rd_in_search, clk, rst_n, rd_vld_r, (state_r == ST_SEARCH), "stray search data")
  `ASSERT_ALWAYS(a_ptr_rng, clk, rst_n, (wp_r <= PTR_MAX) && (cnt_r <= PTR_MAX), "ptr out of range")

endmodule

[hdl/duplicate_filter_ring.sv]
// Duplicate message filter over a ring of recent message identities.
// Input beats carry in_op (0 check and insert, 1 undo last insert) and the
// identity fields; each beat yields exactly one output beat with out_is_dupe.
// The ring sits in one single-port-write RAM with registered read; a check
// scans the filled entries one per cycle through that read port, then reads
// the entry at the write pointer and overwrites it on a miss.
// A check that scans n filled entries (the count capped at the capacity,
// at most 256) passes through the search, save-read, write and done states;
// a check on an empty ring skips the search, and a hit goes from it to done.
// An undo that restores an entry passes through the undo state; an undo with
// nothing saved and any beat with capacity zero go straight to done.
// One item is in flight at a time; in_ready is high while idle, also when
// a result still waits in the output register, so the next beat is taken
// the cycle after the result is loaded. The user must write configuration
// through cfg_wr_en/cfg_index/cfg_wdata only while idle; it goes unchecked.
// Reset (rst_n low, synchronous) clears pointer, count and saved-entry
// flag and sets capacity to 256 with both checks on; the RAM is not cleared.
// A stalled receiver holds out_valid and out_is_dupe; the next result
// waits inside the block and no further beat is taken until it leaves.
module duplicate_filter_ring (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [31:0]                      in_header_crc,
  input  logic [31:0]                      in_date_word,
  input  logic [31:0]                      in_id_hash,
  input  logic [31:0]                      in_id_serial,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_dupe,
  input  logic                             cfg_wr_en,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned CW = dfr_pkg::CNT_W;

  logic [dfr_pkg::CAP_W-1:0]   capacity_r;
  logic                        check_header_r;
  logic                        check_msgid_r;
  logic [CW-1:0]               cap_wide;
  dfr_pkg::cfg_t               cfg;
  dfr_pkg::entry_t             in_entry;
  dfr_pkg::ram_req_t           ram_req;
  logic [dfr_pkg::ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r     <= dfr_pkg::CAP_W'(256);
      check_header_r <= 1'b1;
      check_msgid_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dfr_pkg::REG_CAPACITY:     capacity_r     <= cfg_wdata[dfr_pkg::CAP_W-1:0];
        dfr_pkg::REG_CHECK_HEADER: check_header_r <= cfg_wdata[0];
        dfr_pkg::REG_CHECK_MSGID:  check_msgid_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cap_wide = CW'(capacity_r);
  assign cfg.capacity = (cap_wide > CW'(dfr_pkg::DEPTH)) ?
                        dfr_pkg::PTR_W'(dfr_pkg::DEPTH) : dfr_pkg::PTR_W'(cap_wide);
  assign cfg.check_header = check_header_r;
  assign cfg.check_msgid  = check_msgid_r;

  assign in_entry.crc    = in_header_crc;
  assign in_entry.date   = in_date_word;
  assign in_entry.hash   = in_id_hash;
  assign in_entry.serial = in_id_serial;

  dfr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_entry    (in_entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_dupe (out_is_dupe),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  dfr_ram #(
    .WIDTH (dfr_pkg::ENTRY_W),
    .DEPTH (dfr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
